FILE: rtl/mbss_pkg.sv
`timescale 1ns / 1ps

package mbss_pkg;

    localparam int REG_PATTERN_BYTES = 16;
    localparam int REL_SPAN          = 5;
    localparam int REL_BYTES         = 4;
    localparam int LEN_W             = 5;
    localparam int CFG_INDEX_W       = 3;
    localparam int CFG_DATA_W        = 64;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COMPARE_MASK     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIRECT_REFERENCE = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_ADDRESS     = 3'd5;

    typedef logic [7:0] byte_t;
    typedef logic [REG_PATTERN_BYTES-1:0][7:0] pattern_t;
    typedef logic [REL_BYTES-1:0][7:0] rel_t;

    // compare setup shared by every cell of the window
    typedef struct packed {
        pattern_t                     pattern;
        logic [REG_PATTERN_BYTES-1:0] mask;
        logic [LEN_W-1:0]             len;
        logic [LEN_W-1:0]             need;
    } cell_cfg_t;

endpackage

FILE: rtl/mbss_cell.sv
`timescale 1ns / 1ps

module mbss_cell #(
    parameter int IDX = 0
) (
    input  logic               aclk,
    input  logic               shift_en,
    input  logic               cap_en,
    input  logic [7:0]         byte_in,
    input  mbss_pkg::cell_cfg_t cfg,
    output logic [7:0]         byte_out,
    output logic               ok_out,
    output mbss_pkg::rel_t     rel_out
);
    import mbss_pkg::*;

    byte_t            byte_reg;
    logic             ok_reg;
    logic             in_win;
    logic [LEN_W-1:0] k;
    logic             chk;
    logic             ok_next;

    // k is the pattern position this cell lines up with for the current window
    always_comb begin
        in_win  = int'(cfg.need) > IDX;
        k       = cfg.need - LEN_W'(IDX + 1);
        chk     = in_win && (k < cfg.len) && cfg.mask[k[3:0]];
        ok_next = !chk || (byte_reg == cfg.pattern[k[3:0]]);
        for (int m = 0; m < REL_BYTES; m++) begin
            rel_out[m] = (in_win && k == LEN_W'(m + 1)) ? byte_reg : 8'h00;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            byte_reg <= byte_in;
        end
        if (cap_en) begin
            ok_reg <= ok_next;
        end
    end

    assign byte_out = byte_reg;
    assign ok_out   = ok_reg;

endmodule

FILE: rtl/mbss_result.sv
`timescale 1ns / 1ps

module mbss_result #(
    parameter int OFFSET_BITS = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   in_found,
    input  logic [OFFSET_BITS-1:0] in_start,
    input  logic [31:0]            in_rel,
    input  logic                   direct,
    input  logic [63:0]            base_address,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_found,
    output logic [31:0]            m_match_offset,
    output logic [63:0]            m_result_address
);
    import mbss_pkg::*;

    logic        v3_reg;
    logic        found3_reg;
    logic [31:0] off3_reg;
    logic [63:0] addr3_reg;
    logic [63:0] radd3_reg;
    logic        adv3;
    logic        out_v_reg;
    logic        found_reg;
    logic [31:0] off_reg;
    logic [63:0] addr_reg;

    assign adv3     = !out_v_reg || m_ready;
    assign in_ready = !v3_reg || adv3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                v3_reg <= in_valid;
            end
            if (adv3) begin
                out_v_reg <= v3_reg;
            end
        end
    end

    // match address and rel32 displacement are summed in the output stage
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            found3_reg <= in_found;
            off3_reg   <= in_found ? 32'(in_start) : 32'd0;
            addr3_reg  <= in_found ? base_address + 64'(in_start) : 64'd0;
            radd3_reg  <= (in_found && direct)
                        ? {{32{in_rel[31]}}, in_rel} + 64'(REL_SPAN) : 64'd0;
        end
        if (adv3 && v3_reg) begin
            found_reg <= found3_reg;
            off_reg   <= off3_reg;
            addr_reg  <= addr3_reg + radd3_reg;
        end
    end

    assign m_valid          = out_v_reg;
    assign m_found          = found_reg;
    assign m_match_offset   = off_reg;
    assign m_result_address = addr_reg;

endmodule

FILE: rtl/masked_byte_signature_scanner.sv
`timescale 1ns / 1ps
// throughput: one byte per cycle while m_ready keeps the result output moving; the window
//   shift, the per-cell compare and the two address adders are each a register stage
// reset: synchronous active-low aresetn clears the scan state and the pipeline and
//   sets the registers to pattern_length 1, all others zero; no clearing pass
module masked_byte_signature_scanner #(
    parameter int MAX_PATTERN = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_data_byte,
    input  logic                             s_last_byte,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_found,
    output logic [31:0]                      m_match_offset,
    output logic [63:0]                      m_result_address,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mbss_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mbss_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mbss_pkg::*;

    localparam int CAP = (REG_PATTERN_BYTES < MAX_PATTERN) ? REG_PATTERN_BYTES : MAX_PATTERN;
    localparam int SEEN_W = OFFSET_BITS + 1;

    logic [63:0]                  pattern_low_reg;
    logic [63:0]                  pattern_high_reg;
    logic [REG_PATTERN_BYTES-1:0] compare_mask_reg;
    logic [LEN_W-1:0]             pattern_length_reg;
    logic                         direct_reference_reg;
    logic [63:0]                  base_address_reg;

    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] need;
    cell_cfg_t        cell_cfg;

    logic              v1_reg;
    logic              last1_reg;
    logic [SEEN_W-1:0] seen_reg;
    logic [SEEN_W-1:0] seen_next;
    logic              clear_pend_reg;
    logic              adv1;
    logic              accept;

    logic                   v2_reg;
    logic                   last2_reg;
    logic                   range2_reg;
    logic [OFFSET_BITS-1:0] start2_reg;
    logic [31:0]            rel2_reg;
    logic                   adv2;
    logic                   done_reg;
    logic                   res_ready;

    logic [SEEN_W-1:0] diff;
    rel_t              rel_sum;
    logic              hit;
    logic              emit;

    byte_t                  win   [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] ok_vec;
    rel_t                   rel_c [MAX_PATTERN];

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg      <= 64'd0;
            pattern_high_reg     <= 64'd0;
            compare_mask_reg     <= '0;
            pattern_length_reg   <= LEN_W'(1);
            direct_reference_reg <= 1'b0;
            base_address_reg     <= 64'd0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_PATTERN_LOW:      pattern_low_reg      <= cfg_data;
                CFG_PATTERN_HIGH:     pattern_high_reg     <= cfg_data;
                CFG_COMPARE_MASK:     compare_mask_reg     <= cfg_data[REG_PATTERN_BYTES-1:0];
                CFG_PATTERN_LENGTH:   pattern_length_reg   <= cfg_data[LEN_W-1:0];
                CFG_DIRECT_REFERENCE: direct_reference_reg <= cfg_data[0];
                CFG_BASE_ADDRESS:     base_address_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (pattern_length_reg == '0) begin
            len = LEN_W'(1);
        end else if (pattern_length_reg > LEN_W'(CAP)) begin
            len = LEN_W'(CAP);
        end else begin
            len = pattern_length_reg;
        end
        // direct mode also needs the rel32 bytes after the first one
        need = (direct_reference_reg && len < LEN_W'(REL_SPAN)) ? LEN_W'(REL_SPAN) : len;
        cell_cfg.pattern = {pattern_high_reg, pattern_low_reg};
        cell_cfg.mask    = compare_mask_reg;
        cell_cfg.len     = len;
        cell_cfg.need    = need;
    end

    // stage handshakes
    assign adv2    = !v2_reg || res_ready;
    assign adv1    = !v2_reg || adv2;
    assign s_ready = !v1_reg || adv1;
    assign accept  = s_valid && s_ready;

    // stage 1: window shift and byte count
    always_comb begin
        seen_next = clear_pend_reg ? '0 : seen_reg;
        if (seen_next != '1) begin
            seen_next = seen_next + SEEN_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg         <= 1'b0;
            seen_reg       <= '0;
            clear_pend_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                v1_reg <= s_valid;
            end
            if (accept) begin
                seen_reg       <= seen_next;
                clear_pend_reg <= s_last_byte;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            last1_reg <= s_last_byte;
        end
    end

    genvar j;
    generate
        for (j = 0; j < MAX_PATTERN; j++) begin : g_cell
            mbss_cell #(
                .IDX(j)
            ) u_cell (
                .aclk    (aclk),
                .shift_en(accept),
                .cap_en  (v1_reg && adv1),
                .byte_in ((j == 0) ? s_data_byte : win[(j == 0) ? 0 : j - 1]),
                .cfg     (cell_cfg),
                .byte_out(win[j]),
                .ok_out  (ok_vec[j]),
                .rel_out (rel_c[j])
            );
        end
    endgenerate

    // stage 2: start offset and rel32 gathered from the cells
    assign diff = seen_reg - SEEN_W'(need);

    always_comb begin
        rel_sum = '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            rel_sum = rel_sum | rel_c[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv1) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (v1_reg && adv1) begin
            last2_reg  <= last1_reg;
            range2_reg <= (seen_reg >= SEEN_W'(need)) && !diff[OFFSET_BITS];
            start2_reg <= diff[OFFSET_BITS-1:0];
            rel2_reg   <= direct_reference_reg ? rel_sum : 32'd0;
        end
    end

    // stage 3: first-match decision, items without a result are dropped here
    assign hit  = (&ok_vec) && range2_reg;
    assign emit = !done_reg && (hit || last2_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else if (v2_reg && adv2) begin
            done_reg <= last2_reg ? 1'b0 : (done_reg || hit);
        end
    end

    mbss_result #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_result (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (v2_reg && emit),
        .in_ready        (res_ready),
        .in_found        (hit),
        .in_start        (start2_reg),
        .in_rel          (rel2_reg),
        .direct          (direct_reference_reg),
        .base_address    (base_address_reg),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_found         (m_found),
        .m_match_offset  (m_match_offset),
        .m_result_address(m_result_address)
    );

endmodule
